>>> hdl/lruk_pkg.sv
// Package with the shared types, operation codes and sizes of the LRU-K replacer.
`timescale 1ns / 1ps
package lruk_pkg;

  localparam int FRAME_COUNT = 64;
  localparam int MAX_K       = 8;
  localparam int FRAME_W     = $clog2(FRAME_COUNT);
  localparam int KIDX_W      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int HIST_AW     = FRAME_W + KIDX_W;
  localparam int TIME_W      = 32;
  localparam int K_W         = 4;
  localparam int CNT_W       = 4;
  localparam int TOTAL_W     = 7;
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int FIFO_DEPTH  = 2;
  localparam int K_RESET     = 2;

  // Byte address of the history_depth register on the configuration port.
  localparam logic [1:0] REG_HISTORY_DEPTH = 2'd0;

  localparam logic [MODE_W-1:0] MODE_ACCESS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SETEVIC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PIN     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EVICT   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNTRACKED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PINNED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] frame_no;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  evicted_frame;
    logic [TOTAL_W-1:0]  evictable_count;
  } out_item_t;

  // Item as held in the queue, already classified by the front part.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] frame_no;
    logic               range_err;
  } q_item_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

>>> hdl/lru_k_page_replacer_unit.sv
// Top level of the LRU-K page replacer: command port, queue, back part and APB register.
// Flow: an accepted item is popped from the queue into the back part in IDLE and its result is
// registered in EXEC; an evict goes on through SCAN, one frame per cycle, and strobes its result in FIN.
// The back part takes a new item only once it is back in IDLE, after the last one is done;
// a 2-item queue lets start be taken while an earlier item is still being worked on.
// Reset: synchronous rst_n clears flags, counts, clock and queue and sets K to 2; timestamp memories keep their contents.
`timescale 1ns / 1ps
module lru_k_page_replacer_unit
  import lruk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Command channel.
  input  logic        start,
  input  in_item_t    in_item,
  output logic        busy,
  // Result channel: one strobe per item.
  output logic        out_valid,
  output out_item_t   out_item,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [K_W-1:0] k_r, k_nxt;
  logic           cfg_wr;
  logic           pop;
  q_head_t        head;

  // The single register, history_depth, sits at byte address zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_HISTORY_DEPTH);
  assign k_nxt  = cfg_wr ? pwdata[K_W-1:0] : k_r;
  assign prdata = {{(32-K_W){1'b0}}, k_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_W'(K_RESET);
    end else begin
      k_r <= k_nxt;
    end
  end

  // The front part accepts and classifies items while the back part is busy.
  lruk_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .pop     (pop),
    .head    (head)
  );

  // The back part owns the frame table and runs the victim scan.
  lruk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .k_cfg     (k_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> hdl/lruk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lruk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> hdl/lruk_front.sv
// Front part: takes items from the command port, classifies them and queues them.
`timescale 1ns / 1ps
module lruk_front
  import lruk_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  output logic     busy,
  input  logic     pop,
  output q_head_t  head
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  q_item_t              slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]       fill_r, fill_nxt;
  logic                 push;
  logic                 do_pop;
  q_item_t              cls;

  // Modes that address a frame reject an index past the table.
  always_comb begin
    cls.mode      = in_item.mode;
    cls.frame_no  = in_item.frame_no;
    cls.range_err = (in_item.mode <= MODE_REMOVE) &&
                    ({1'b0, in_item.frame_no} >= (FRAME_W+1)'(FRAME_COUNT));
  end

  assign busy   = (fill_r == (PTR_W+1)'(FIFO_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (fill_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  assign head.valid = (fill_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

endmodule

>>> hdl/lruk_back.sv
// Back part: frame table state, the victim scan and result generation.
`timescale 1ns / 1ps
module lruk_back
  import lruk_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [K_W-1:0]  k_cfg,
  input  q_head_t         head,
  output logic            pop,
  output logic            out_valid,
  output out_item_t       out_item
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  q_item_t              op_r;
  logic [TIME_W-1:0]    clock_r;
  logic                 tracked_r [FRAME_COUNT];
  logic                 evict_r   [FRAME_COUNT];
  logic [CNT_W-1:0]     cnt_r     [FRAME_COUNT];
  logic [KIDX_W-1:0]    head_r    [FRAME_COUNT];
  logic [TOTAL_W-1:0]   total_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  logic [FRAME_W-1:0]   scan_idx_r;
  logic                 issue_done_r;
  logic                 pend_act_r, pend_v_r, pend_full_r;
  logic [FRAME_W-1:0]   pend_idx_r;
  logic                 best_found_r, best_full_r;
  logic [FRAME_W-1:0]   best_idx_r;
  logic [TIME_W-1:0]    best_time_r;

  logic [CNT_W-1:0]     k_eff;
  logic [KIDX_W-1:0]    k_sel;
  logic [TIME_W-1:0]    clock_inc;
  logic [FRAME_W-1:0]   f;
  logic [KIDX_W-1:0]    head_new;
  logic                 hist_we, first_we;
  logic [HIST_AW-1:0]   hist_waddr, hist_raddr;
  logic [TIME_W-1:0]    hist_rdata, first_rdata, cand_time;
  logic                 cand_wins;

  // K clamped into 1..MAX_K.
  always_comb begin
    if (k_cfg == '0) begin
      k_eff = CNT_W'(1);
    end else if (k_cfg > K_W'(MAX_K)) begin
      k_eff = CNT_W'(MAX_K);
    end else begin
      k_eff = CNT_W'(k_cfg);
    end
    k_sel = KIDX_W'(k_eff - 1'b1);
  end

  assign f         = op_r.frame_no;
  assign clock_inc = (clock_r == '1) ? clock_r : clock_r + 1'b1;
  assign head_new  = tracked_r[f] ? head_r[f] + 1'b1 : '0;

  // History is a ring per frame; the newest entry sits at the head pointer.
  assign hist_we    = (state_r == S_EXEC) && !op_r.range_err && (op_r.mode == MODE_ACCESS);
  assign first_we   = hist_we && !tracked_r[f];
  assign hist_waddr = {f, head_new};
  assign hist_raddr = {scan_idx_r, head_r[scan_idx_r] - k_sel};

  lruk_ram #(.WIDTH(TIME_W), .DEPTH(FRAME_COUNT * MAX_K)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (clock_inc),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  lruk_ram #(.WIDTH(TIME_W), .DEPTH(FRAME_COUNT)) u_first (
    .clk   (clk),
    .we    (first_we),
    .waddr (f),
    .wdata (clock_inc),
    .raddr (scan_idx_r),
    .rdata (first_rdata)
  );

  assign cand_time = pend_full_r ? hist_rdata : first_rdata;
  always_comb begin
    if (!best_found_r) begin
      cand_wins = 1'b1;
    end else if (pend_full_r != best_full_r) begin
      cand_wins = !pend_full_r;
    end else begin
      cand_wins = cand_time < best_time_r;
    end
  end

  assign pop = (state_r == S_IDLE) && head.valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (head.valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (!op_r.range_err && op_r.mode == MODE_EVICT) state_nxt = S_SCAN;
        else state_nxt = S_IDLE;
      end
      S_SCAN: if (issue_done_r && !pend_act_r) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clock_r      <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_act_r   <= 1'b0;
      pend_v_r     <= 1'b0;
      best_found_r <= 1'b0;
      issue_done_r <= 1'b0;
      scan_idx_r   <= '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        tracked_r[i] <= 1'b0;
        evict_r[i]   <= 1'b0;
        cnt_r[i]     <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          scan_idx_r   <= '0;
          issue_done_r <= 1'b0;
          pend_act_r   <= 1'b0;
          pend_v_r     <= 1'b0;
          best_found_r <= 1'b0;
        end
        S_EXEC: begin
          out_r.status        <= ST_OK;
          out_r.evicted_frame <= '0;
          out_r.evictable_count <= total_r;
          if (op_r.range_err) begin
            out_r.status <= ST_RANGE;
            out_valid_r  <= 1'b1;
          end else if (op_r.mode == MODE_EVICT) begin
            out_valid_r <= 1'b0;
          end else begin
            out_valid_r <= 1'b1;
            case (op_r.mode)
              MODE_ACCESS: begin
                clock_r <= clock_inc;
                if (!tracked_r[f]) begin
                  tracked_r[f] <= 1'b1;
                  evict_r[f]   <= 1'b0;
                  cnt_r[f]     <= CNT_W'(1);
                end else if (cnt_r[f] < k_eff) begin
                  cnt_r[f] <= cnt_r[f] + 1'b1;
                end
              end
              MODE_SETEVIC: begin
                if (!tracked_r[f]) begin
                  out_r.status <= ST_UNTRACKED;
                end else if (!evict_r[f]) begin
                  evict_r[f]            <= 1'b1;
                  total_r               <= total_r + 1'b1;
                  out_r.evictable_count <= total_r + 1'b1;
                end
              end
              MODE_PIN: begin
                if (!tracked_r[f]) begin
                  out_r.status <= ST_UNTRACKED;
                end else if (evict_r[f]) begin
                  evict_r[f]            <= 1'b0;
                  total_r               <= total_r - 1'b1;
                  out_r.evictable_count <= total_r - 1'b1;
                end
              end
              MODE_REMOVE: begin
                if (tracked_r[f]) begin
                  if (!evict_r[f]) begin
                    out_r.status <= ST_PINNED;
                  end else begin
                    tracked_r[f]          <= 1'b0;
                    evict_r[f]            <= 1'b0;
                    cnt_r[f]              <= '0;
                    total_r               <= total_r - 1'b1;
                    out_r.evictable_count <= total_r - 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // Read is issued for one frame per cycle; each frame's compare runs in the next cycle.
          pend_act_r  <= !issue_done_r;
          pend_v_r    <= !issue_done_r && tracked_r[scan_idx_r] && evict_r[scan_idx_r];
          pend_full_r <= cnt_r[scan_idx_r] >= k_eff;
          pend_idx_r  <= scan_idx_r;
          if (!issue_done_r) begin
            if (scan_idx_r == FRAME_W'(FRAME_COUNT - 1)) issue_done_r <= 1'b1;
            else scan_idx_r <= scan_idx_r + 1'b1;
          end
          if (pend_v_r && cand_wins) begin
            best_found_r <= 1'b1;
            best_full_r  <= pend_full_r;
            best_idx_r   <= pend_idx_r;
            best_time_r  <= cand_time;
          end
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          if (!best_found_r) begin
            out_r.status          <= ST_EMPTY;
            out_r.evicted_frame   <= '0;
            out_r.evictable_count <= total_r;
          end else begin
            tracked_r[best_idx_r] <= 1'b0;
            evict_r[best_idx_r]   <= 1'b0;
            cnt_r[best_idx_r]     <= '0;
            total_r               <= total_r - 1'b1;
            out_r.status          <= ST_OK;
            out_r.evicted_frame   <= best_idx_r;
            out_r.evictable_count <= total_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r <= head.item;
    end
    if (hist_we) begin
      head_r[f] <= head_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> hdl/lruk_checker.sv
// Port-level checker of the LRU-K replacer and its bind to the top level.
`timescale 1ns / 1ps
module lruk_checker
  import lruk_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input out_item_t out_item
);

  // No result can appear in the cycle right after reset.
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // Every reported status is a defined code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK || out_item.status == ST_RANGE ||
                   out_item.status == ST_UNTRACKED || out_item.status == ST_PINNED ||
                   out_item.status == ST_EMPTY))
    else $error("undefined status code");

  // A failed item never names a victim.
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> (out_item.evicted_frame == '0))
    else $error("victim reported on failed item");

  // The evictable count can never exceed the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.evictable_count <= TOTAL_W'(FRAME_COUNT)))
    else $error("evictable count beyond frame table");

  // An empty evict reports no evictable frames.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_EMPTY) |-> (out_item.evictable_count == '0))
    else $error("nothing to evict with frames evictable");

endmodule

bind lru_k_page_replacer_unit lruk_checker u_lruk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_item  (out_item)
);

>>> test/testbench.sv
// Self-checking testbench for the LRU-K page replacer unit.
`timescale 1ns / 1ps
module testbench;
  import lruk_pkg::*;

  // Mode codes that the block ignores; they must answer ok and change nothing.
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  // The longest item is an evict, which scans every frame; leave generous margin.
  localparam int DRAIN_CYCLES = FRAME_COUNT + 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1850;

  logic        clk;
  logic        rst_n;
  logic        start;
  in_item_t    in_item;
  logic        busy;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lru_k_page_replacer_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the replacer state, kept in step with every accepted item.
  // ---------------------------------------------------------------------------
  logic [K_W-1:0]     shadow_depth;
  logic [TIME_W-1:0]  shadow_clock;
  logic               shadow_tracked   [FRAME_COUNT];
  logic               shadow_evictable [FRAME_COUNT];
  logic [CNT_W-1:0]   shadow_count     [FRAME_COUNT];
  logic [TIME_W-1:0]  shadow_first     [FRAME_COUNT];
  logic [TIME_W-1:0]  shadow_history   [FRAME_COUNT][MAX_K];
  logic [TOTAL_W-1:0] shadow_total;

  // Results the block still owes, oldest first.
  out_item_t pending_results[$];

  int mismatches;
  int results_seen;
  int items_sent;
  int evictions_seen;
  int mode_hits[8];

  function automatic void clear_shadow();
    shadow_depth = K_W'(K_RESET);
    shadow_clock = '0;
    shadow_total = '0;
    for (int f = 0; f < FRAME_COUNT; f++) begin
      shadow_tracked[f]   = 1'b0;
      shadow_evictable[f] = 1'b0;
      shadow_count[f]     = '0;
    end
  endfunction

  // K as the block uses it: zero counts as one, anything above MAX_K as MAX_K.
  function automatic int unsigned active_k();
    int unsigned k;
    k = shadow_depth;
    if (k < 1) k = 1;
    if (k > MAX_K) k = MAX_K;
    return k;
  endfunction

  // True when frame a is a better victim than frame b. Frames short of K
  // accesses have infinite distance and go first, ordered by first access.
  function automatic bit evicts_sooner(int a, int b, int unsigned k);
    bit full_a;
    bit full_b;
    logic [TIME_W-1:0] ta;
    logic [TIME_W-1:0] tb;
    full_a = shadow_count[a] >= k;
    full_b = shadow_count[b] >= k;
    if (full_a != full_b) return !full_a;
    if (!full_a) begin
      ta = shadow_first[a];
      tb = shadow_first[b];
    end else begin
      ta = shadow_history[a][k-1];
      tb = shadow_history[b][k-1];
    end
    return ta < tb;
  endfunction

  function automatic void forget_frame(int f);
    shadow_tracked[f]   = 1'b0;
    shadow_evictable[f] = 1'b0;
    shadow_count[f]     = '0;
    shadow_total        = shadow_total - 1'b1;
  endfunction

  // Applies one item to the shadow state and returns the result it must give.
  function automatic out_item_t replace_step(in_item_t cmd);
    out_item_t   res;
    int          f;
    int unsigned k;
    int          best;
    bit          found;
    res = '0;
    f   = cmd.frame_no;
    k   = active_k();
    res.status = ST_OK;
    if (cmd.mode <= MODE_REMOVE && f >= FRAME_COUNT) begin
      res.status = ST_RANGE;
    end else begin
      case (cmd.mode)
        MODE_ACCESS: begin
          if (shadow_clock != '1) shadow_clock = shadow_clock + 1'b1;
          if (!shadow_tracked[f]) begin
            shadow_tracked[f]    = 1'b1;
            shadow_evictable[f]  = 1'b0;
            shadow_count[f]      = CNT_W'(1);
            shadow_first[f]      = shadow_clock;
            shadow_history[f][0] = shadow_clock;
          end else begin
            for (int i = MAX_K - 1; i > 0; i--) shadow_history[f][i] = shadow_history[f][i-1];
            shadow_history[f][0] = shadow_clock;
            if (shadow_count[f] < k) shadow_count[f] = shadow_count[f] + 1'b1;
          end
        end
        MODE_SETEVIC, MODE_PIN: begin
          if (!shadow_tracked[f]) begin
            res.status = ST_UNTRACKED;
          end else if (cmd.mode == MODE_SETEVIC && !shadow_evictable[f]) begin
            shadow_evictable[f] = 1'b1;
            shadow_total        = shadow_total + 1'b1;
          end else if (cmd.mode == MODE_PIN && shadow_evictable[f]) begin
            shadow_evictable[f] = 1'b0;
            shadow_total        = shadow_total - 1'b1;
          end
        end
        MODE_REMOVE: begin
          // Removing an untracked frame is a quiet no-op.
          if (shadow_tracked[f]) begin
            if (!shadow_evictable[f]) res.status = ST_PINNED;
            else forget_frame(f);
          end
        end
        MODE_EVICT: begin
          found = 1'b0;
          best  = 0;
          // Ascending scan with a strict compare: on equal stamps the lower frame wins.
          for (int i = 0; i < FRAME_COUNT; i++) begin
            if (shadow_tracked[i] && shadow_evictable[i]) begin
              if (!found || evicts_sooner(i, best, k)) begin
                best  = i;
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            res.status = ST_EMPTY;
          end else begin
            forget_frame(best);
            res.evicted_frame = FRAME_W'(best);
          end
        end
        default: ;
      endcase
    end
    res.evictable_count = shadow_total;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest pending expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d frame=%0d count=%0d",
                   out_item.status, out_item.evicted_frame, out_item.evictable_count);
      end else begin
        want = pending_results.pop_front();
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d: expected status=%0d frame=%0d count=%0d, got status=%0d frame=%0d count=%0d",
                     results_seen, want.status, want.evicted_frame, want.evictable_count,
                     out_item.status, out_item.evicted_frame, out_item.evictable_count);
        end
      end
    end
  end

  // Watchdog: the run may not go this long without any item moving either way.
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge; handshakes are seen on the rising.
  // ---------------------------------------------------------------------------

  // Offers one item after an idle gap and holds it until the block takes it.
  // The expectation is typed in when given, else taken from the shadow model.
  task automatic issue_item(in_item_t cmd, int gap, bit typed, out_item_t typed_want);
    out_item_t predicted;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = replace_step(cmd);
    pending_results.push_back(typed ? typed_want : predicted);
    items_sent++;
    mode_hits[cmd.mode]++;
    if (cmd.mode == MODE_EVICT && predicted.status == ST_OK) evictions_seen++;
  endtask

  task automatic park_sender();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Lets every owed result arrive, then lets the block settle before any write.
  task automatic wait_until_drained();
    park_sender();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(logic [K_W-1:0] depth);
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_HISTORY_DEPTH;
    pwdata  <= {$urandom() & 32'hFFFF_FFF0} | depth;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_depth = depth;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[K_W-1:0] !== depth) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: history depth reads %0d, expected %0d", readback[K_W-1:0], depth);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t want;
  } script_row_t;

  script_row_t script[$];

  function automatic void add_row(logic [MODE_W-1:0] mode, logic [FRAME_W-1:0] frame,
                                  bit typed = 1'b0, logic [STATUS_W-1:0] status = ST_OK,
                                  logic [FRAME_W-1:0] victim = '0,
                                  logic [TOTAL_W-1:0] count = '0);
    script_row_t row;
    row.cmd.mode                = mode;
    row.cmd.frame_no            = frame;
    row.typed                   = typed;
    row.want.status             = status;
    row.want.evicted_frame      = victim;
    row.want.evictable_count    = count;
    script.push_back(row);
  endfunction

  function automatic void build_script();
    // Fresh after reset: nothing is tracked yet.
    add_row(MODE_PIN,     6'd5,  1'b1, ST_UNTRACKED, 6'd0, 7'd0);
    add_row(MODE_SETEVIC, 6'd63, 1'b1, ST_UNTRACKED, 6'd0, 7'd0);
    add_row(MODE_EVICT,   6'd0,  1'b1, ST_EMPTY,     6'd0, 7'd0);
    add_row(MODE_REMOVE,  6'd9,  1'b1, ST_OK,        6'd0, 7'd0);
    // Track the two extreme frames; frame 0 reaches K, frame 63 stays short.
    add_row(MODE_ACCESS,  6'd0);
    add_row(MODE_ACCESS,  6'd63);
    add_row(MODE_ACCESS,  6'd0);
    add_row(MODE_REMOVE,  6'd0,  1'b1, ST_PINNED,    6'd0, 7'd0);
    add_row(MODE_SETEVIC, 6'd0,  1'b1, ST_OK,        6'd0, 7'd1);
    add_row(MODE_SETEVIC, 6'd0,  1'b1, ST_OK,        6'd0, 7'd1);
    add_row(MODE_SETEVIC, 6'd63, 1'b1, ST_OK,        6'd0, 7'd2);
    add_row(MODE_PIN,     6'd63, 1'b1, ST_OK,        6'd0, 7'd1);
    add_row(MODE_PIN,     6'd63, 1'b1, ST_OK,        6'd0, 7'd1);
    add_row(MODE_SETEVIC, 6'd63);
    // The ignored modes, with every frame bit exercised.
    add_row(MODE_SPARE_5, 6'd42);
    add_row(MODE_SPARE_6, 6'd21);
    add_row(MODE_SPARE_7, 6'd63);
    // Frame 63 has too few accesses and so leaves first, then frame 0.
    add_row(MODE_EVICT,   6'd17);
    add_row(MODE_EVICT,   6'd0);
    add_row(MODE_EVICT,   6'd0,  1'b1, ST_EMPTY,     6'd0, 7'd0);
    // An evicted frame is untracked again.
    add_row(MODE_PIN,     6'd63, 1'b1, ST_UNTRACKED, 6'd0, 7'd0);
    // Track, free and remove one frame.
    add_row(MODE_ACCESS,  6'd42);
    add_row(MODE_SETEVIC, 6'd42);
    add_row(MODE_REMOVE,  6'd42, 1'b1, ST_OK,        6'd0, 7'd0);
  endfunction

  // Picks a frame: mostly a small working set so that frames are reused,
  // sometimes anywhere in the table.
  function automatic logic [FRAME_W-1:0] pick_frame();
    if ($urandom_range(0, 9) < 7) return FRAME_W'($urandom_range(0, 11));
    return FRAME_W'($urandom_range(0, FRAME_COUNT - 1));
  endfunction

  // Most items follow the access, release, evict life of a page; a few are
  // pins, removes and ignored modes.
  function automatic in_item_t pick_item();
    in_item_t cmd;
    int roll;
    roll = $urandom_range(0, 99);
    cmd.frame_no = pick_frame();
    if (roll < 40)      cmd.mode = MODE_ACCESS;
    else if (roll < 62) cmd.mode = MODE_SETEVIC;
    else if (roll < 71) cmd.mode = MODE_PIN;
    else if (roll < 80) cmd.mode = MODE_REMOVE;
    else if (roll < 96) cmd.mode = MODE_EVICT;
    else                cmd.mode = MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
    return cmd;
  endfunction

  // Depth settings walked in turn: reset value, the limits, both clamped ends, two values between.
  logic [K_W-1:0] depth_plan[7] = '{4'd2, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};

  initial begin
    out_item_t no_want;
    int        gap;
    int        per_phase;
    bit        hurry;
    no_want = '0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    evictions_seen = 0;
    foreach (mode_hits[m]) mode_hits[m] = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    clear_shadow();
    build_script();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset value of K.
    foreach (script[r])
      issue_item(script[r].cmd, $urandom_range(0, 7), script[r].typed, script[r].want);
    wait_until_drained();

    // Random part, split into phases that each run under one K setting.
    // Frames tracked in one phase carry over, so K also changes under live state.
    per_phase = RANDOM_ITEMS / $size(depth_plan);
    foreach (depth_plan[p]) begin
      write_depth(depth_plan[p]);
      for (int n = 0; n < per_phase; n++) begin
        // Every third stretch of 48 items runs back to back with no gaps.
        hurry = ((n / 48) % 3) == 1;
        gap   = hurry ? 0 : $urandom_range(0, 7);
        issue_item(pick_item(), gap, 1'b0, no_want);
      end
      wait_until_drained();
    end

    $display("Ran %0d items (%0d accesses, %0d evicts of which %0d found a victim) over %0d K settings.",
             items_sent, mode_hits[MODE_ACCESS], mode_hits[MODE_EVICT], evictions_seen,
             $size(depth_plan));
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/lruk_pkg.sv
hdl/lruk_ram.sv
hdl/lruk_front.sv
hdl/lruk_back.sv
hdl/lru_k_page_replacer_unit.sv
hdl/lruk_checker.sv
test/testbench.sv
